### hw/rtl/rvfr_pkg.sv
// Package: payload structs, command encoding and helpers for the RTP frame reassembly block
`timescale 1ns / 1ps

package rvfr_pkg;

    // Queue between classifier and frame accumulator
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Picture type codes
    localparam logic [2:0] PicUnknown = 3'd0;
    localparam logic [2:0] PicI       = 3'd1;
    localparam logic [2:0] PicD       = 3'd4;

    // Saturation value of the frame byte sum
    localparam logic [31:0] BytesMax = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] seq_number;
        logic [31:0] time_stamp;
        logic        marker;
        logic [2:0]  picture_type;
        logic [15:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        loss_valid;
        logic [15:0] loss_first;
        logic [15:0] loss_count;
        logic        frame_valid;
        logic [34:0] frame_bits;
        logic [2:0]  frame_kind;
    } t_out_item;

    // What the accumulator does with a classified packet
    typedef enum logic [1:0] {
        OP_DROP         = 2'd0, // late or duplicate, nothing to the frame
        OP_ADD          = 2'd1, // joins the current frame
        OP_CLOSE_WITH   = 2'd2, // joins, then the frame closes (marker)
        OP_CLOSE_BEFORE = 2'd3  // closes the frame, then starts the next one
    } t_op;

    typedef struct packed {
        logic        accepted;
        logic        loss_valid;
        logic [15:0] loss_first;
        logic [15:0] loss_count;
        t_op         op;
        logic [15:0] payload_length;
        logic [2:0]  picture_type;
    } t_cmd;

    // Map a raw picture type to the reported kind
    function automatic logic [2:0] kind_of(input logic [2:0] raw);
        return (raw >= PicI && raw <= PicD) ? raw : PicUnknown;
    endfunction

    // Saturating add of a packet length onto the byte sum
    function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [15:0] len);
        logic [32:0] sum;
        sum = {1'b0, acc} + {17'd0, len};
        return sum[32] ? BytesMax : sum[31:0];
    endfunction

endpackage

### hw/rtl/rvfr_front.sv
// Classifier: sequence/timestamp checks, gap report, drop decision
`timescale 1ns / 1ps

module rvfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rvfr_pkg::t_in_item i_item,
    input  logic              i_ready,
    output logic              o_push,
    output rvfr_pkg::t_cmd    o_cmd
);
    import rvfr_pkg::*;

    logic [31:0] r_lowest_time, n_lowest_time;
    logic [15:0] r_highest_seq, n_highest_seq;

    logic        seeded;
    logic [16:0] hs_next;
    logic        gap;
    logic [31:0] eff_time;
    logic [15:0] eff_seq;
    logic        keep;
    logic        later;
    logic [15:0] gap_count;

    // Compares against the stored state; an unseeded block compares with the packet itself
    always_comb begin
        seeded    = (r_lowest_time != 32'd0);
        hs_next   = {1'b0, r_highest_seq} + 17'd1;
        gap       = seeded && ({1'b0, i_item.seq_number} > hs_next);
        gap_count = i_item.seq_number - r_highest_seq - 16'd1;
        eff_time  = seeded ? r_lowest_time : i_item.time_stamp;
        eff_seq   = seeded ? r_highest_seq : i_item.seq_number;
        keep      = !((i_item.time_stamp < eff_time) || (i_item.seq_number <= eff_seq));
        later     = i_item.time_stamp > eff_time;
    end

    // Command for the accumulator
    always_comb begin
        o_push               = i_valid && i_ready;
        o_cmd.accepted       = keep;
        o_cmd.loss_valid     = gap;
        o_cmd.loss_first     = gap ? hs_next[15:0] : 16'd0;
        o_cmd.loss_count     = gap ? gap_count : 16'd0;
        o_cmd.payload_length = i_item.payload_length;
        o_cmd.picture_type   = i_item.picture_type;
        priority if (!keep) begin
            o_cmd.op = OP_DROP;
        end else if (later) begin
            o_cmd.op = OP_CLOSE_BEFORE;
        end else if (i_item.marker) begin
            o_cmd.op = OP_CLOSE_WITH;
        end else begin
            o_cmd.op = OP_ADD;
        end
    end

    // State update per transfer
    always_comb begin
        n_lowest_time = r_lowest_time;
        n_highest_seq = r_highest_seq;
        if (o_push) begin
            if (!seeded) begin
                n_lowest_time = i_item.time_stamp;
                n_highest_seq = i_item.seq_number;
            end
            if (keep) begin
                n_highest_seq = i_item.seq_number;
                if (later) begin
                    n_lowest_time = i_item.time_stamp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest_time <= 32'd0;
            r_highest_seq <= 16'd0;
        end else begin
            r_lowest_time <= n_lowest_time;
            r_highest_seq <= n_highest_seq;
        end
    end

endmodule

### hw/rtl/rvfr_queue.sv
// Short command queue between classifier and accumulator
`timescale 1ns / 1ps

module rvfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rvfr_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output rvfr_pkg::t_cmd o_cmd
);
    import rvfr_pkg::*;

    t_cmd                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QueueCntW-1:0] r_count, n_count;
    logic                 do_pop;

    always_comb begin
        o_ready  = (r_count != QueueCntW'(QueueDepth));
        o_valid  = (r_count != '0);
        o_cmd    = r_mem[r_rd_ptr];
        do_pop   = i_pop && o_valid;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### hw/rtl/rvfr_back.sv
// Frame accumulator: byte sum, picture type, frame close and result register
`timescale 1ns / 1ps

module rvfr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rvfr_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rvfr_pkg::t_out_item o_out_data
);
    import rvfr_pkg::*;

    logic [31:0] r_frame_bytes, n_frame_bytes;
    logic [2:0]  r_frame_type, n_frame_type;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic [31:0] added_bytes;
    logic [2:0]  added_type;
    logic [31:0] close_bytes;
    logic [2:0]  close_type;
    logic        closes;

    // Take a command whenever the result register is free or being drained
    always_comb begin
        o_pop       = i_valid && (!r_out_valid || !i_out_stall);
        added_bytes = sat_add(r_frame_bytes, i_cmd.payload_length);
        added_type  = (r_frame_type == PicUnknown) ? i_cmd.picture_type : r_frame_type;
        closes      = 1'b0;
        close_bytes = r_frame_bytes;
        close_type  = r_frame_type;

        n_frame_bytes = r_frame_bytes;
        n_frame_type  = r_frame_type;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;

        if (o_pop) begin
            unique case (i_cmd.op)
                OP_DROP: begin
                end
                OP_ADD: begin
                    n_frame_bytes = added_bytes;
                    n_frame_type  = added_type;
                end
                OP_CLOSE_WITH: begin
                    closes        = 1'b1;
                    close_bytes   = added_bytes;
                    close_type    = added_type;
                    n_frame_bytes = 32'd0;
                    n_frame_type  = PicUnknown;
                end
                OP_CLOSE_BEFORE: begin
                    // next frame starts from this packet alone
                    closes        = 1'b1;
                    n_frame_bytes = {16'd0, i_cmd.payload_length};
                    n_frame_type  = i_cmd.picture_type;
                end
                default: begin
                end
            endcase
            n_out_valid       = 1'b1;
            n_out.accepted    = i_cmd.accepted;
            n_out.loss_valid  = i_cmd.loss_valid;
            n_out.loss_first  = i_cmd.loss_first;
            n_out.loss_count  = i_cmd.loss_count;
            n_out.frame_valid = closes && (close_bytes != 32'd0);
            n_out.frame_bits  = n_out.frame_valid ? {close_bytes, 3'b000} : 35'd0;
            n_out.frame_kind  = n_out.frame_valid ? kind_of(close_type) : PicUnknown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= 32'd0;
            r_frame_type  <= PicUnknown;
            r_out_valid   <= 1'b0;
        end else begin
            r_frame_bytes <= n_frame_bytes;
            r_frame_type  <= n_frame_type;
            r_out_valid   <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/rtp_video_frame_reassembly_top.sv
// Top level of the RTP video frame reassembly block
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one RTP video
//   packet header per transfer. Output channel (o_out_valid / i_out_stall /
//   o_out_data) gives exactly one result per packet, in packet order: kept or
//   dropped, any sequence gap before it, and the frame it closed, if any.
//   Throughput: one packet per cycle while the receiver does not stall.
//   The classifier keeps the timestamp and sequence state and decides in
//   the cycle of the transfer; the accumulator updates the frame byte sum
//   and type one command per cycle on the same condition. Path to result
//   valid: classifier to the two-entry command queue, accumulator to the result register.
//   When the receiver stalls, the result register holds, the queue fills, and
//   o_in_stall rises once the queue is full; no packet is lost.
//   Reset (synchronous, active low) clears the stored timestamp, highest
//   sequence number, frame byte sum and picture type, and empties the queue
//   and result register. The first packet after reset seeds the state and is
//   reported as dropped.
module rtp_video_frame_reassembly_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rvfr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rvfr_pkg::t_out_item o_out_data
);
    import rvfr_pkg::*;

    logic q_ready;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    assign o_in_stall = !q_ready;

    rvfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_ready (q_ready),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    rvfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    rvfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A frame only closes on a kept packet, and its size is a nonzero byte count
    a_frame_on_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_valid) |->
            (o_out_data.accepted && o_out_data.frame_bits[2:0] == 3'd0 &&
             o_out_data.frame_bits != 35'd0))
        else $error("frame reported without a kept packet or with bad size");

    // Gap fields are zero without a gap, and a reported gap is never empty
    a_gap_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.loss_valid ? (o_out_data.loss_count != 16'd0) :
            (o_out_data.loss_first == 16'd0 && o_out_data.loss_count == 16'd0)))
        else $error("inconsistent sequence gap fields");

    // No frame, no size or kind
    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.frame_valid) |->
            (o_out_data.frame_bits == 35'd0 && o_out_data.frame_kind == PicUnknown))
        else $error("frame fields set without a frame");

    // Queue never overflows: stall is raised before a push could be lost
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready)
        else $error("command pushed into a full queue");

endmodule

### test/rtp_video_frame_reassembly_top_tb.sv
// Self-checking testbench for the RTP video frame reassembly block
`timescale 1ns / 1ps

module rtp_video_frame_reassembly_top_tb;

    import rvfr_pkg::*;

    localparam int         ClkPeriod   = 10;
    localparam int         CycleLimit  = 400000;
    localparam int         DrainCycles = 10;
    localparam int         HoldCycles  = 300;
    localparam int         MaxPrints   = 40;
    localparam logic [2:0] PicP        = 3'd2;
    localparam logic [2:0] PicB        = 3'd3;
    localparam logic [15:0] LenMax     = 16'hFFFF;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    rtp_video_frame_reassembly_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Shadow of the block state, cleared like the reset does
    logic [31:0] cur_time   = '0;
    logic [15:0] top_seq    = '0;
    logic [31:0] frame_sum  = '0;
    logic [2:0]  frame_type = PicUnknown;

    t_out_item   pending_reports[$];
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          cycle_count    = 0;
    int          items_sent     = 0;
    bit          in_gaps_on     = 1'b1;
    bit          out_gaps_on    = 1'b1;
    bit          hold_go        = 1'b0;
    int          hold_left      = 0;
    int          stall_left     = 0;

    // Stream position of the random packet generator
    logic [15:0] gen_seq = 16'd30;
    logic [31:0] gen_ts  = 32'd5000;

    // Clock
    initial begin
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("rtp_video_frame_reassembly_top: mismatch");
            $finish;
        end
    end

    // Add a packet's bytes to the open frame, saturating
    task automatic gather_packet(input logic [15:0] len, input logic [2:0] ptype);
        logic [32:0] total;
        total = {1'b0, frame_sum} + {17'd0, len};
        frame_sum = total[32] ? 32'hFFFF_FFFF : total[31:0];
        if (frame_type == PicUnknown) frame_type = ptype;
    endtask

    // Work out the result of one packet and advance the shadow state
    task automatic predict_frame_result(input t_in_item pkt, output t_out_item res);
        logic        later;
        logic [31:0] closed_sum;
        logic [2:0]  closed_type;
        res = '0;
        closed_sum = '0;
        closed_type = PicUnknown;
        // Unseeded: this packet seeds the time and sequence
        if (cur_time == 32'd0) begin
            cur_time = pkt.time_stamp;
            top_seq = pkt.seq_number;
        end else if ({1'b0, pkt.seq_number} > {1'b0, top_seq} + 17'd1) begin
            res.loss_valid = 1'b1;
            res.loss_first = top_seq + 16'd1;
            res.loss_count = pkt.seq_number - top_seq - 16'd1;
        end
        // Keep only packets that are neither late nor stale
        if (pkt.time_stamp >= cur_time && pkt.seq_number > top_seq) begin
            later = pkt.time_stamp > cur_time;
            res.accepted = 1'b1;
            top_seq = pkt.seq_number;
            if (later || pkt.marker) begin
                if (!later) gather_packet(pkt.payload_length, pkt.picture_type);
                closed_sum = frame_sum;
                closed_type = frame_type;
                frame_sum = '0;
                frame_type = PicUnknown;
                // a newer timestamp opens the next frame with this packet
                if (later) begin
                    cur_time = pkt.time_stamp;
                    gather_packet(pkt.payload_length, pkt.picture_type);
                end
                if (closed_sum != 32'd0) begin
                    res.frame_valid = 1'b1;
                    res.frame_bits = {closed_sum, 3'b000};
                    res.frame_kind = (closed_type >= PicI && closed_type <= PicD) ?
                                     closed_type : PicUnknown;
                end
            end else begin
                gather_packet(pkt.payload_length, pkt.picture_type);
            end
        end
    endtask

    // Offer one packet, wait for its transfer, then record the expected result
    task automatic send_packet(input t_in_item pkt);
        t_out_item res;
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= pkt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_frame_result(pkt, res);
        pending_reports.push_back(res);
        items_sent++;
    endtask

    task automatic send_fields(input logic [15:0] seq, input logic [31:0] ts,
                               input logic mark, input logic [2:0] ptype,
                               input logic [15:0] len);
        t_in_item pkt;
        pkt.seq_number = seq;
        pkt.time_stamp = ts;
        pkt.marker = mark;
        pkt.picture_type = ptype;
        pkt.payload_length = len;
        send_packet(pkt);
    endtask

    // A packet the block must drop: stale sequence or late timestamp
    task automatic send_noise_packet();
        t_in_item pkt;
        pkt.marker = 1'($urandom_range(0, 1));
        pkt.picture_type = 3'($urandom_range(0, 7));
        pkt.payload_length = 16'($urandom);
        case ($urandom_range(0, 2))
            0: begin
                pkt.seq_number = gen_seq - 16'($urandom_range(0, 4));
                pkt.time_stamp = gen_ts + $urandom_range(0, 5000);
            end
            1: begin
                pkt.seq_number = gen_seq + 16'($urandom_range(1, 6));
                pkt.time_stamp = $urandom_range(0, gen_ts - 1);
            end
            default: begin
                pkt.seq_number = 16'($urandom);
                pkt.time_stamp = $urandom % gen_ts;
            end
        endcase
        send_packet(pkt);
    endtask

    // One frame of in-order packets with random content and some noise
    task automatic send_random_frame();
        t_in_item pkt;
        int       n;
        gen_ts += ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1 << 20)
                                               : $urandom_range(1, 3000);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            gen_seq += ($urandom_range(0, 9) == 0) ? 16'($urandom_range(2, 12)) : 16'd1;
            pkt.seq_number = gen_seq;
            pkt.time_stamp = gen_ts;
            pkt.marker = (i == n - 1) ? ($urandom_range(0, 3) != 0)
                                      : ($urandom_range(0, 15) == 0);
            pkt.picture_type = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0:       pkt.payload_length = 16'd0;
                1:       pkt.payload_length = LenMax;
                default: pkt.payload_length = 16'($urandom_range(1, 1500));
            endcase
            send_packet(pkt);
            if ($urandom_range(0, 7) == 0) send_noise_packet();
        end
    endtask

    // Zero timestamp leaves the block unseeded; next packet seeds it
    task automatic test_seeding();
        send_fields(16'd5, 32'd0, 1'b0, PicUnknown, 16'd0);
        send_fields(16'd0, 32'd1000, 1'b1, 3'd7, LenMax);
    endtask

    // Marker close, empty frames, later-timestamp close, picture kinds
    task automatic test_frame_closing();
        send_fields(16'd1, 32'd1000, 1'b0, PicI, 16'd100);
        send_fields(16'd2, 32'd1000, 1'b0, PicUnknown, LenMax);
        send_fields(16'd3, 32'd1000, 1'b1, PicP, 16'd1);
        send_fields(16'd4, 32'd1000, 1'b1, PicUnknown, 16'd0);
        send_fields(16'd5, 32'd2000, 1'b0, PicB, 16'd40);
        send_fields(16'd6, 32'd2000, 1'b0, PicI, 16'd8);
        send_fields(16'd7, 32'd3000, 1'b1, 3'd5, 16'd12);
        send_fields(16'd8, 32'd3000, 1'b1, PicD, 16'd0);
        send_fields(16'd9, 32'd3000, 1'b1, PicD, 16'd20);
        send_fields(16'd10, 32'd3000, 1'b0, 3'd6, 16'd0);
        send_fields(16'd11, 32'd4000, 1'b0, PicP, 16'd9);
    endtask

    // Late, duplicate and older packets; gaps on kept and dropped packets
    task automatic test_drops_and_gaps();
        send_fields(16'd12, 32'd3999, 1'b0, PicI, 16'd50);
        send_fields(16'd11, 32'd4000, 1'b1, PicI, 16'd5);
        send_fields(16'd10, 32'd4000, 1'b0, PicB, 16'd5);
        send_fields(16'd15, 32'd4000, 1'b0, PicI, 16'd6);
        send_fields(16'd20, 32'd100, 1'b0, PicP, 16'd7);
        send_fields(16'd21, 32'd4000, 1'b1, PicUnknown, 16'd3);
    endtask

    // Receiver holds off while the sender keeps pushing
    task automatic test_full_stall();
        int start_count;
        start_count = items_sent;
        in_gaps_on = 1'b0;
        hold_go = 1'b1;
        while (items_sent - start_count < 30) send_random_frame();
        in_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < 1450) send_random_frame();
    endtask

    // Near the end of the run: no idling on either side
    task automatic test_back_to_back();
        int start_count;
        start_count = items_sent;
        in_gaps_on = 1'b0;
        out_gaps_on = 1'b0;
        while (items_sent - start_count < 200) send_random_frame();
    endtask

    // Top sequence number and timestamp: widest gap, then a duplicate
    task automatic test_sequence_end();
        send_fields(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 3'd7, LenMax);
        send_fields(16'hFFFF, 32'hFFFF_FFFF, 1'b0, PicI, LenMax);
    endtask

    // Receiver stall: long hold-off on request, else random bursts
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MaxPrints)
            $display("ERROR: result %0d %s: got %0h, expected %0h",
                     results_seen, field, got, want);
    endtask

    // Compare each result transfer against the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_out_data), 64'd0);
            end else begin
                want = pending_reports.pop_front();
                if (o_out_data.accepted !== want.accepted)
                    report_mismatch("accepted", 64'(o_out_data.accepted), 64'(want.accepted));
                if (o_out_data.loss_valid !== want.loss_valid)
                    report_mismatch("loss_valid", 64'(o_out_data.loss_valid),
                                    64'(want.loss_valid));
                if (o_out_data.loss_first !== want.loss_first)
                    report_mismatch("loss_first", 64'(o_out_data.loss_first),
                                    64'(want.loss_first));
                if (o_out_data.loss_count !== want.loss_count)
                    report_mismatch("loss_count", 64'(o_out_data.loss_count),
                                    64'(want.loss_count));
                if (o_out_data.frame_valid !== want.frame_valid)
                    report_mismatch("frame_valid", 64'(o_out_data.frame_valid),
                                    64'(want.frame_valid));
                if (o_out_data.frame_bits !== want.frame_bits)
                    report_mismatch("frame_bits", 64'(o_out_data.frame_bits),
                                    64'(want.frame_bits));
                if (o_out_data.frame_kind !== want.frame_kind)
                    report_mismatch("frame_kind", 64'(o_out_data.frame_kind),
                                    64'(want.frame_kind));
            end
            results_seen++;
        end
    end

    // Test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_seeding();
        test_frame_closing();
        test_drops_and_gaps();
        test_full_stall();
        test_random_traffic();
        test_back_to_back();
        test_sequence_end();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("rtp_video_frame_reassembly_top: match");
        end else begin
            $display("rtp_video_frame_reassembly_top: mismatch");
        end
        $finish;
    end

endmodule
